@@ design/rabs_pkg.sv @@
package rabs_pkg;

  localparam int IDX_W      = 19;
  localparam int CHAN_W     = 8;
  localparam int NUM_CHAN   = 3;
  localparam int CNT_W      = 8;
  localparam int ALPHA_W    = 9;
  localparam int FRAC_W     = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;
  localparam int BG_W       = NUM_CHAN * CHAN_W;
  localparam int ENTRY_W    = BG_W + CNT_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DIFF_THRESHOLD   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BLEND_ALPHA      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SELECTIVE_UPDATE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ABSORB_LIMIT     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COLOR_MODE       = 3'd4;

  // register reset values
  localparam logic [CHAN_W-1:0]  RST_DIFF_THRESHOLD = 8'd25;
  localparam logic [ALPHA_W-1:0] RST_BLEND_ALPHA    = 9'd13;
  localparam logic [CNT_W-1:0]   RST_ABSORB_LIMIT   = 8'd50;

  // request codes
  localparam logic REQ_INIT    = 1'b0;
  localparam logic REQ_PROCESS = 1'b1;

  localparam logic [ALPHA_W-1:0] ALPHA_ONE = 9'd256;
  localparam logic [CNT_W-1:0]   CNT_MAX   = 8'd255;

  typedef struct packed {
    logic              req_type;
    logic [IDX_W-1:0]  pixel_index;
    logic [CHAN_W-1:0] chan_zero;
    logic [CHAN_W-1:0] chan_one;
    logic [CHAN_W-1:0] chan_two;
  } pix_in_t;

  typedef struct packed {
    logic             foreground;
    logic [IDX_W-1:0] out_index;
  } pix_out_t;

  typedef struct packed {
    logic [CHAN_W-1:0]  diff_threshold;
    logic [ALPHA_W-1:0] blend_alpha;
    logic               selective_update;
    logic [CNT_W-1:0]   absorb_limit;
    logic               color_mode;
  } cfg_t;

  typedef struct packed {
    logic              over;
    logic [CHAN_W-1:0] blend;
  } lane_res_t;

endpackage

@@ design/rabs_ram.sv @@
module rabs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/rabs_lane.sv @@
module rabs_lane (
  input  logic [rabs_pkg::CHAN_W-1:0]  pix,
  input  logic [rabs_pkg::CHAN_W-1:0]  bg,
  input  logic [rabs_pkg::ALPHA_W-1:0] alpha,
  input  logic [rabs_pkg::CHAN_W-1:0]  threshold,
  output rabs_pkg::lane_res_t          res
);
  import rabs_pkg::*;

  localparam int PROD_W = ALPHA_W + CHAN_W + 2;
  localparam int ACC_W  = PROD_W + 1;
  localparam logic [FRAC_W-1:0] HALF = FRAC_W'(1 << (FRAC_W - 1));

  logic signed [CHAN_W:0]   diff;
  logic        [CHAN_W-1:0] mag;
  logic signed [PROD_W-1:0] prod;
  logic signed [ACC_W-1:0]  acc;

  // b + a*(p-b)/256 with rounding, same as (a*p + (256-a)*b + 128)/256
  always_comb begin
    diff = $signed({1'b0, pix}) - $signed({1'b0, bg});
    mag  = diff[CHAN_W] ? CHAN_W'(-diff) : diff[CHAN_W-1:0];
    prod = $signed({1'b0, alpha}) * diff;
    acc  = ACC_W'($signed({1'b0, bg, HALF})) + ACC_W'(prod);
    res.over  = mag > threshold;
    res.blend = acc[FRAC_W +: CHAN_W];
  end

endmodule

@@ design/rabs_merge.sv @@
module rabs_merge (
  input  rabs_pkg::pix_in_t                             item,
  input  logic [rabs_pkg::ENTRY_W-1:0]                  entry,
  input  rabs_pkg::lane_res_t [rabs_pkg::NUM_CHAN-1:0]  lanes,
  input  rabs_pkg::cfg_t                                cfg,
  output logic                                          foreground,
  output logic [rabs_pkg::ENTRY_W-1:0]                  entry_next
);
  import rabs_pkg::*;

  logic [NUM_CHAN-1:0][CHAN_W-1:0] pix;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] bgc;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] bg_new;
  logic [NUM_CHAN-1:0]             used;
  logic [NUM_CHAN-1:0]             over;
  logic [CNT_W-1:0]                count;
  logic [CNT_W-1:0]                cnt_sat;
  logic                            hit;
  logic                            absorb;
  logic                            blend_en;

  always_comb begin
    pix   = {item.chan_two, item.chan_one, item.chan_zero};
    bgc   = entry[BG_W-1:0];
    count = entry[ENTRY_W-1 -: CNT_W];
    for (int c = 0; c < NUM_CHAN; c++) begin
      used[c] = (c == 0) || cfg.color_mode;
      over[c] = lanes[c].over;
    end
    hit      = |(over & used);
    cnt_sat  = (hit && count != CNT_MAX) ? count + CNT_W'(1) : count;
    absorb   = cnt_sat > cfg.absorb_limit;
    blend_en = !(cfg.selective_update && hit);
    for (int c = 0; c < NUM_CHAN; c++) begin
      if (!used[c]) begin
        bg_new[c] = bgc[c];
      end else if (absorb) begin
        bg_new[c] = pix[c];
      end else if (blend_en) begin
        bg_new[c] = lanes[c].blend;
      end else begin
        bg_new[c] = bgc[c];
      end
    end
    if (item.req_type == REQ_PROCESS) begin
      foreground = hit;
      entry_next = {hit ? cnt_sat : CNT_W'(0), bg_new};
    end else begin
      foreground = 1'b0;
      entry_next = {CNT_W'(0), pix};
    end
  end

endmodule

@@ design/running_average_background_subtraction.sv @@
// channel   direction  handshake             payload
// in        input      in_valid / in_ready   in_data   (rabs_pkg::pix_in_t)
// out       output     out_valid / out_ready out_data  (rabs_pkg::pix_out_t)
// cfg       input      cfg_we                cfg_index, cfg_data
//
// one pixel per cycle sustained while out is not stalled; a taken beat passes stage 1, then the output register
// the per-pixel state sits in one single-port-write ram, one read and one write a cycle
// reset sets the registers to their defaults; the ram is not cleared, init a pixel first
// a stalled output holds its register, the item behind it waits, and in_ready drops
module running_average_background_subtraction #(
  parameter int FRAME_PIXELS = 524288
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  rabs_pkg::pix_in_t                  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output rabs_pkg::pix_out_t                 out_data,
  input  logic                               cfg_we,
  input  logic [rabs_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [rabs_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import rabs_pkg::*;

  localparam int ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

  // configuration registers
  cfg_t               cfg;
  logic [ALPHA_W-1:0] alpha_sat;

  // stage 1: item waiting on its ram read
  logic               s1_valid;
  pix_in_t            s1_item;
  logic               s1_in_range;
  logic [ADDR_W-1:0]  s1_addr;
  logic               s1_adv;
  logic               accept;

  // address forms of the incoming index
  logic [IDX_W+ADDR_W-1:0] in_idx_ext;
  logic [ADDR_W-1:0]       in_addr;
  logic                    in_range;

  // ram and write-back bypass
  logic [ENTRY_W-1:0] ram_rdata;
  logic               ram_we;
  logic [ENTRY_W-1:0] entry;
  logic [ENTRY_W-1:0] entry_next;
  logic               lw_valid;
  logic [ADDR_W-1:0]  lw_addr;
  logic [ENTRY_W-1:0] lw_data;

  logic [NUM_CHAN-1:0][CHAN_W-1:0] s1_pix;
  logic [NUM_CHAN-1:0][CHAN_W-1:0] s1_bg;
  lane_res_t [NUM_CHAN-1:0]        lanes;
  logic                            merge_fg;

  // config writes; the user must write only while idle, the block does not enforce it
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.diff_threshold   <= RST_DIFF_THRESHOLD;
      cfg.blend_alpha      <= RST_BLEND_ALPHA;
      cfg.selective_update <= 1'b0;
      cfg.absorb_limit     <= RST_ABSORB_LIMIT;
      cfg.color_mode       <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DIFF_THRESHOLD:   cfg.diff_threshold   <= cfg_data[CHAN_W-1:0];
        REG_BLEND_ALPHA:      cfg.blend_alpha      <= cfg_data[ALPHA_W-1:0];
        REG_SELECTIVE_UPDATE: cfg.selective_update <= cfg_data[0];
        REG_ABSORB_LIMIT:     cfg.absorb_limit     <= cfg_data[CNT_W-1:0];
        REG_COLOR_MODE:       cfg.color_mode       <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // alpha above one saturates to one
  assign alpha_sat = (cfg.blend_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg.blend_alpha;

  // handshake: stage 1 moves on whenever the output register is free or draining
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;
  assign accept   = in_valid && in_ready;

  assign in_idx_ext = {{ADDR_W{1'b0}}, in_data.pixel_index};
  assign in_addr    = in_idx_ext[ADDR_W-1:0];
  assign in_range   = 32'(in_data.pixel_index) < FRAME_PIXELS;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_item     <= in_data;
      s1_in_range <= in_range;
      s1_addr     <= in_addr;
    end
  end

  // ram read issued with the accepted beat, data lands with stage 1
  assign ram_we = s1_adv && s1_in_range;

  rabs_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (FRAME_PIXELS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (s1_addr),
    .wdata (entry_next),
    .re    (accept),
    .raddr (in_addr),
    .rdata (ram_rdata)
  );

  // the last write may land on the same edge as our read; bypass it by address
  always_ff @(posedge clk) begin
    if (rst) begin
      lw_valid <= 1'b0;
    end else if (ram_we) begin
      lw_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ram_we) begin
      lw_addr <= s1_addr;
      lw_data <= entry_next;
    end
  end

  assign entry = (lw_valid && lw_addr == s1_addr) ? lw_data : ram_rdata;

  // one lane per color channel
  assign s1_pix = {s1_item.chan_two, s1_item.chan_one, s1_item.chan_zero};
  assign s1_bg  = entry[BG_W-1:0];

  for (genvar c = 0; c < NUM_CHAN; c++) begin : g_lane
    rabs_lane u_lane (
      .pix       (s1_pix[c]),
      .bg        (s1_bg[c]),
      .alpha     (alpha_sat),
      .threshold (cfg.diff_threshold),
      .res       (lanes[c])
    );
  end

  // merge: foreground vote, counter, blend or absorb, or the init store
  rabs_merge u_merge (
    .item       (s1_item),
    .entry      (entry),
    .lanes      (lanes),
    .cfg        (cfg),
    .foreground (merge_fg),
    .entry_next (entry_next)
  );

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_data.foreground <= s1_in_range && merge_fg;
      out_data.out_index  <= s1_item.pixel_index;
    end
  end

  // read data must not move while its item is held in stage 1
  a_rdata_hold: assert property (@(posedge clk) disable iff (rst)
    s1_valid && !s1_adv |=> $stable(ram_rdata))
    else $error("ram read data changed under a stalled item");

  // writes only come from an in-range item leaving stage 1
  a_write_src: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> s1_valid && s1_in_range && (!out_valid || out_ready))
    else $error("ram write without a departing in-range item");

  // init and out-of-range beats never report foreground
  a_fg_quiet: assert property (@(posedge clk) disable iff (rst)
    s1_adv && (!s1_in_range || s1_item.req_type == REQ_INIT) |=> !out_data.foreground)
    else $error("foreground set on init or out-of-range beat");

endmodule

@@ tb/running_average_background_subtraction_tb.sv @@
module running_average_background_subtraction_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import rabs_pkg::*;

  localparam int FRAME_PIXELS = 524288;

  // how a generated channel value relates to the pixel's last init value
  typedef enum int {CH_NEAR, CH_FAR, CH_ANY} chan_style_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  pix_in_t               in_data = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  pix_out_t              out_data;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // beats waiting to be driven, marks waiting to come out
  pix_in_t               pending_pixels [$];
  pix_out_t              expected_marks [$];
  logic                  in_took = 1'b0;
  bit                    calm = 1'b0;
  int                    mismatches = 0;

  // predictor state: only pixels that were initialized ever get an entry
  cfg_t                  cfg_shadow;
  logic [BG_W-1:0]       bg_store [int unsigned];
  logic [CNT_W-1:0]      fg_count [int unsigned];

  // stimulus side: last init value per pixel, and every pixel ever initialized
  logic [BG_W-1:0]       pix_base [int unsigned];
  int unsigned           known_px [$];

  running_average_background_subtraction #(
    .FRAME_PIXELS(FRAME_PIXELS)
  ) i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // classify one pixel and update the background and hit counter it touches
  function automatic pix_out_t classify_pixel(pix_in_t px);
    pix_out_t        res;
    int unsigned     key, nch, alpha, cnt, c, d;
    int unsigned     p [3];
    int unsigned     b [3];
    logic [BG_W-1:0] word;
    bit              fg;
    key = px.pixel_index;
    res.foreground = 1'b0;
    res.out_index = px.pixel_index;
    // index past the frame: no state touched, background mark
    if (key >= FRAME_PIXELS) return res;
    p[0] = px.chan_zero;
    p[1] = px.chan_one;
    p[2] = px.chan_two;
    // init stores all three channels, even in gray mode
    if (px.req_type == REQ_INIT) begin
      bg_store[key] = {px.chan_two, px.chan_one, px.chan_zero};
      fg_count[key] = '0;
      return res;
    end
    nch = cfg_shadow.color_mode ? NUM_CHAN : 1;
    // alpha beyond one saturates to one
    alpha = (cfg_shadow.blend_alpha > ALPHA_ONE) ? ALPHA_ONE : cfg_shadow.blend_alpha;
    word = bg_store[key];
    fg = 1'b0;
    for (c = 0; c < NUM_CHAN; c++) b[c] = word[c*CHAN_W +: CHAN_W];
    for (c = 0; c < nch; c++) begin
      d = (p[c] > b[c]) ? p[c] - b[c] : b[c] - p[c];
      if (d > cfg_shadow.diff_threshold) fg = 1'b1;
    end
    // running average with rounding, skipped on foreground in selective mode
    if (!(cfg_shadow.selective_update && fg)) begin
      for (c = 0; c < nch; c++) b[c] = (alpha * p[c] + (256 - alpha) * b[c] + 128) >> FRAC_W;
    end
    cnt = fg_count[key] + fg;
    if (cnt > CNT_MAX) cnt = CNT_MAX;
    // stuck foreground gets absorbed into the background
    if (cnt > cfg_shadow.absorb_limit) begin
      for (c = 0; c < nch; c++) b[c] = p[c];
    end
    fg_count[key] = fg ? CNT_W'(cnt) : '0;
    bg_store[key] = {CHAN_W'(b[2]), CHAN_W'(b[1]), CHAN_W'(b[0])};
    res.foreground = fg;
    return res;
  endfunction

  // input driver: changes only at the falling edge, holds until the beat is taken
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (pending_pixels.size() != 0 && (calm || $urandom_range(0, 99) >= 10)) begin
        in_valid <= 1'b1;
        in_data <= pending_pixels.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
    // output back-pressure
    out_ready <= calm || ($urandom_range(0, 99) >= 10);
  end

  // rising edge: predict on every input beat, check every output beat
  always @(posedge clk) begin : sample_beats
    pix_out_t want;
    in_took <= in_valid && in_ready;
    if (!rst) begin
      if (in_valid && in_ready) expected_marks.push_back(classify_pixel(in_data));
      if (out_valid && out_ready) begin
        if (expected_marks.size() == 0) begin
          $display("%0t: unexpected out beat, expected none, got %p", $time, out_data);
          mismatches++;
        end else begin
          want = expected_marks.pop_front();
          if (out_data.foreground !== want.foreground) begin
            $display("%0t: foreground mismatch at index %0d, expected %0b, got %0b",
                     $time, want.out_index, want.foreground, out_data.foreground);
            mismatches++;
          end
          if (out_data.out_index !== want.out_index) begin
            $display("%0t: out_index mismatch, expected %0d, got %0d",
                     $time, want.out_index, out_data.out_index);
            mismatches++;
          end
        end
      end
    end
  end

  task automatic push_init(input int unsigned idx, input logic [CHAN_W-1:0] c0,
                           input logic [CHAN_W-1:0] c1, input logic [CHAN_W-1:0] c2);
    pix_in_t px;
    px.req_type = REQ_INIT;
    px.pixel_index = IDX_W'(idx);
    px.chan_zero = c0;
    px.chan_one = c1;
    px.chan_two = c2;
    pending_pixels.push_back(px);
    if (!pix_base.exists(idx)) known_px.push_back(idx);
    pix_base[idx] = {c2, c1, c0};
  endtask

  task automatic push_proc(input int unsigned idx, input logic [CHAN_W-1:0] c0,
                           input logic [CHAN_W-1:0] c1, input logic [CHAN_W-1:0] c2);
    pix_in_t px;
    px.req_type = REQ_PROCESS;
    px.pixel_index = IDX_W'(idx);
    px.chan_zero = c0;
    px.chan_one = c1;
    px.chan_two = c2;
    pending_pixels.push_back(px);
  endtask

  function automatic logic [CHAN_W-1:0] rand_chan();
    return CHAN_W'($urandom_range(0, 255));
  endfunction

  // values near the threshold edge, far from the base, or anywhere
  function automatic logic [CHAN_W-1:0] pick_chan(logic [CHAN_W-1:0] base,
                                                  chan_style_t style);
    int spread, v;
    spread = int'(cfg_shadow.diff_threshold) + 4;
    case (style)
      CH_NEAR: v = int'(base) + int'($urandom_range(0, 2 * spread)) - spread;
      CH_FAR:  v = int'(base ^ 8'h80) + int'($urandom_range(0, 15)) - 8;
      default: v = int'($urandom_range(0, 255));
    endcase
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return CHAN_W'(v);
  endfunction

  // registers change only with nothing in flight
  task automatic wait_drained();
    while (pending_pixels.size() != 0 || in_valid || expected_marks.size() != 0)
      @(negedge clk);
    // two-stage pipe, leave it a little slack
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= CFG_DATA_W'(val);
    case (idx)
      REG_DIFF_THRESHOLD:   cfg_shadow.diff_threshold = CHAN_W'(val);
      REG_BLEND_ALPHA:      cfg_shadow.blend_alpha = ALPHA_W'(val);
      REG_SELECTIVE_UPDATE: cfg_shadow.selective_update = val[0];
      REG_ABSORB_LIMIT:     cfg_shadow.absorb_limit = CNT_W'(val);
      REG_COLOR_MODE:       cfg_shadow.color_mode = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int unsigned thr, input int unsigned alpha,
                            input int unsigned sel, input int unsigned lim,
                            input int unsigned color);
    write_reg(REG_DIFF_THRESHOLD, thr);
    write_reg(REG_BLEND_ALPHA, alpha);
    write_reg(REG_SELECTIVE_UPDATE, sel);
    write_reg(REG_ABSORB_LIMIT, lim);
    write_reg(REG_COLOR_MODE, color);
  endtask

  // mostly well-formed runs on a small pool, so hit counters climb, with re-inits as noise
  task automatic random_phase(input int n_items);
    int unsigned     pool [6];
    int unsigned     idx;
    logic [BG_W-1:0] b;
    chan_style_t     style;
    int              r, k;
    for (k = 0; k < 6; k++) begin
      pool[k] = $urandom_range(0, FRAME_PIXELS - 1);
      push_init(pool[k], rand_chan(), rand_chan(), rand_chan());
    end
    for (k = 0; k < n_items; k++) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        push_init(pool[$urandom_range(0, 5)], rand_chan(), rand_chan(), rand_chan());
      end else begin
        if (r < 15) idx = known_px[$urandom_range(0, known_px.size() - 1)];
        else idx = pool[$urandom_range(0, 5)];
        r = $urandom_range(0, 99);
        style = (r < 45) ? CH_NEAR : (r < 85) ? CH_FAR : CH_ANY;
        b = pix_base[idx];
        push_proc(idx, pick_chan(b[7:0], style), pick_chan(b[15:8], style),
                  pick_chan(b[23:16], style));
      end
    end
    wait_drained();
  endtask

  initial begin : stimulus
    int unsigned sat_px;
    int          k;
    cfg_shadow.diff_threshold = RST_DIFF_THRESHOLD;
    cfg_shadow.blend_alpha = RST_BLEND_ALPHA;
    cfg_shadow.selective_update = 1'b0;
    cfg_shadow.absorb_limit = RST_ABSORB_LIMIT;
    cfg_shadow.color_mode = 1'b0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed beats under the reset defaults, gray mode
    push_init(0, 8'h00, 8'h00, 8'h00);
    push_init(FRAME_PIXELS - 1, 8'hFF, 8'hFF, 8'hFF);
    // difference right at the threshold, other channels ignored in gray
    push_proc(0, 8'd25, 8'hFF, 8'hFF);
    push_proc(0, 8'd27, 8'hFF, 8'hFF);
    push_proc(0, 8'hFF, 8'h00, 8'h00);
    push_proc(FRAME_PIXELS - 1, 8'h00, 8'h00, 8'h00);
    push_proc(FRAME_PIXELS - 1, 8'hFF, 8'h00, 8'h00);
    push_proc(FRAME_PIXELS - 1, 8'hE5, 8'hFF, 8'hFF);
    // gray init still keeps all three channels, checked later in color mode
    push_init(19'h55555, 8'h5A, 8'hA5, 8'h0F);
    push_proc(19'h55555, 8'h5A, 8'h00, 8'hFF);
    push_init(19'h2AAAA, 8'hFF, 8'h00, 8'h80);
    push_proc(19'h2AAAA, 8'h00, 8'hFF, 8'h7F);
    push_proc(19'h2AAAA, 8'hFF, 8'h00, 8'h80);
    // re-init clears the hit counter
    push_init(0, 8'h80, 8'h80, 8'h80);
    push_proc(0, 8'h80, 8'h80, 8'h80);
    wait_drained();

    // extremes: zero threshold, frozen background, absorb on first hit, color
    set_config(0, 0, 0, 0, 1);
    push_proc(19'h55555, 8'h5A, 8'hA5, 8'h0F);
    push_proc(19'h2AAAA, 8'h00, 8'hFF, 8'h7F);
    random_phase(150);

    // never foreground, full-weight blend, gray
    set_config(255, ALPHA_ONE, 1, 255, 0);
    random_phase(120);

    // alpha register past one saturates, quick absorb
    set_config(40, 511, 1, 3, 1);
    random_phase(150);

    // stretch with no idling on either side
    set_config(25, 128, 0, 7, 0);
    @(posedge clk);
    calm = 1'b1;
    random_phase(150);
    @(posedge clk);
    calm = 1'b0;

    // hit counter saturation: limit at max never absorbs, one lower does
    set_config(10, 300, 1, 255, 1);
    sat_px = $urandom_range(0, FRAME_PIXELS - 1);
    push_init(sat_px, 8'h20, 8'h40, 8'h60);
    for (k = 0; k < 262; k++) begin
      push_proc(sat_px, CHAN_W'(8'hA0 + $urandom_range(0, 15)),
                CHAN_W'(8'hC0 + $urandom_range(0, 15)), CHAN_W'(8'hE0 + $urandom_range(0, 15)));
    end
    wait_drained();
    write_reg(REG_ABSORB_LIMIT, 254);
    push_proc(sat_px, 8'hA5, 8'hC5, 8'hE5);
    push_proc(sat_px, 8'hA5, 8'hC5, 8'hE5);
    push_proc(sat_px, 8'h20, 8'h40, 8'h60);
    wait_drained();

    // anything goes
    set_config($urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 1),
               $urandom_range(0, 12), $urandom_range(0, 1));
    random_phase(200);

    repeat (20) @(posedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin : watchdog
    #5_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

@@ sim.f @@
design/rabs_pkg.sv
design/rabs_ram.sv
design/rabs_lane.sv
design/rabs_merge.sv
design/running_average_background_subtraction.sv
tb/running_average_background_subtraction_tb.sv
